// ===== sv/wnr_pkg.sv =====
// ----------------------------------------------------------------------------
// Wildcard name rewrite: shared package
// Character, name and rule types, codes and tag constants.
// ----------------------------------------------------------------------------
package wnr_pkg;

  localparam int NAME_LEN = 14;
  localparam int CHAR_W   = 8;
  localparam int HITS_W   = 9;

  localparam logic [CHAR_W-1:0] WILDCARD   = 8'h2A;
  localparam logic [47:0]       TAG_ATOM   = 48'h20204D4F5441;
  localparam logic [47:0]       TAG_HETATM = 48'h4D5441544548;

  typedef logic [NAME_LEN-1:0][CHAR_W-1:0] name_t;

  typedef struct packed {
    name_t subst;
    name_t match;
  } rule_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

  typedef enum logic [1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_APPEND  = 2'd1,
    ACT_REWRITE = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_REWRITTEN = 2'd0,
    ST_APPENDED  = 2'd1,
    ST_FULL      = 2'd2,
    ST_CLEARED   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } state_t;

endpackage

// ===== sv/wnr_rule_mem.sv =====
// ----------------------------------------------------------------------------
// Wildcard name rewrite: rule table
// Single-port-write, single-port-read rule memory with registered read data.
// ----------------------------------------------------------------------------
module wnr_rule_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  wnr_pkg::mem_ctl_t ctl,
  input  logic [AW-1:0]    wr_addr,
  input  wnr_pkg::rule_t   wr_data,
  input  logic [AW-1:0]    rd_addr,
  output wnr_pkg::rule_t   rd_data
);
  import wnr_pkg::*;

  rule_t mem [DEPTH];
  rule_t rd_data_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/wnr_match_unit.sv =====
// ----------------------------------------------------------------------------
// Wildcard name rewrite: match and overlay unit
// Tests one rule against the current name and applies its replacement.
// ----------------------------------------------------------------------------
module wnr_match_unit (
  input  wnr_pkg::name_t name_in,
  input  wnr_pkg::rule_t rule,
  output wnr_pkg::name_t name_out,
  output logic           hit
);
  import wnr_pkg::*;

  logic [NAME_LEN-1:0] char_ok;

  always_comb begin
    for (int k = 0; k < NAME_LEN; k++) begin
      char_ok[k] = (rule.match[k] == WILDCARD) || (rule.match[k] == name_in[k]);
    end
    hit = &char_ok;
    for (int k = 0; k < NAME_LEN; k++) begin
      name_out[k] = (hit && rule.subst[k] != WILDCARD) ? rule.subst[k] : name_in[k];
    end
  end

endmodule

// ===== sv/wildcard_name_rewrite.sv =====
// Clear, append and untouched names pass from accept to S_DONE and on to out_valid.
// A rewrite walks the rule table in S_WALK: the table is read one rule per cycle
// through a single memory read port, and one match unit is applied per rule.
// Throughput: one item at a time; in_ready is low from accept until the result is registered.
// Reset (rst_n, synchronous): rule table emptied, no result pending; rule memory not cleared.
// ----------------------------------------------------------------------------
// Wildcard name rewrite: top level
// Sequencer that stores rename rules and walks them in load order over a name.
// ----------------------------------------------------------------------------
module wildcard_name_rewrite #(
  parameter int MAX_RULES = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_action,
  input  logic [47:0]          in_record_tag,
  input  logic [63:0]          in_text_low,
  input  logic [47:0]          in_text_high,
  input  logic [63:0]          in_replace_low,
  input  logic [47:0]          in_replace_high,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [63:0]          out_low,
  output logic [47:0]          out_high,
  output logic [wnr_pkg::HITS_W-1:0] out_hits,
  output logic [1:0]           out_status
);
  import wnr_pkg::*;

  localparam int CW = $clog2(MAX_RULES + 1);
  localparam int AW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     rd_idx_r;
  logic              rd_vld_r;
  name_t             name_r;
  logic [HITS_W-1:0] hits_r;
  status_t           status_r;
  logic [63:0]       out_low_r;
  logic [47:0]       out_high_r;
  logic [HITS_W-1:0] out_hits_r;
  status_t           out_status_r;
  logic              out_valid_r;

  mem_ctl_t mem_ctl;
  rule_t    wr_rule;
  rule_t    rd_rule;
  name_t    mu_name;
  logic     mu_hit;
  logic     accept;
  logic     room;
  logic     eligible;
  logic     out_load;

  assign accept   = in_valid && in_ready;
  assign room     = count_r < CW'(MAX_RULES);
  assign eligible = (in_record_tag == TAG_ATOM) || (in_record_tag == TAG_HETATM);
  assign wr_rule  = '{subst: {in_replace_high, in_replace_low},
                      match: {in_text_high, in_text_low}};

  wnr_rule_mem #(.DEPTH(MAX_RULES), .AW(AW)) u_mem (
    .clk    (clk),
    .ctl    (mem_ctl),
    .wr_addr(count_r[AW-1:0]),
    .wr_data(wr_rule),
    .rd_addr(rd_idx_r[AW-1:0]),
    .rd_data(rd_rule)
  );

  wnr_match_unit u_match (
    .name_in (name_r),
    .rule    (rd_rule),
    .name_out(mu_name),
    .hit     (mu_hit)
  );

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_action == ACT_REWRITE && eligible && count_r != '0) begin
            state_nxt = S_WALK;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_WALK: begin
        if (!mem_ctl.rd_en && !rd_vld_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output and control decode.
  always_comb begin
    in_ready      = (state_r == S_IDLE);
    mem_ctl.wr_en = (state_r == S_IDLE) && in_valid && in_action == ACT_APPEND && room;
    mem_ctl.rd_en = (state_r == S_WALK) && (rd_idx_r < count_r);
    out_load      = (state_r == S_DONE) && (!out_valid_r || out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= mem_ctl.rd_en;
      if (accept && in_action == ACT_CLEAR) begin
        count_r <= '0;
      end else if (mem_ctl.wr_en) begin
        count_r <= count_r + CW'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_idx_r <= '0;
      hits_r   <= '0;
      case (in_action)
        ACT_CLEAR: begin
          name_r   <= '0;
          status_r <= ST_CLEARED;
        end
        ACT_APPEND: begin
          name_r   <= '0;
          status_r <= room ? ST_APPENDED : ST_FULL;
        end
        default: begin
          name_r   <= {in_text_high, in_text_low};
          status_r <= ST_REWRITTEN;
        end
      endcase
    end else begin
      if (mem_ctl.rd_en) begin
        rd_idx_r <= rd_idx_r + CW'(1);
      end
      // Each rule sees the name as left by the rules before it.
      if (rd_vld_r) begin
        name_r <= mu_name;
        if (mu_hit) begin
          hits_r <= hits_r + HITS_W'(1);
        end
      end
    end
    if (out_load) begin
      {out_high_r, out_low_r} <= name_r;
      out_hits_r              <= hits_r;
      out_status_r            <= status_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_low    = out_low_r;
  assign out_high   = out_high_r;
  assign out_hits   = out_hits_r;
  assign out_status = out_status_r;

endmodule

// ===== sv/wnr_checker.sv =====
// ----------------------------------------------------------------------------
// Wildcard name rewrite: port checker
// Checks the top level's ports over time; attached by a bind statement.
// ----------------------------------------------------------------------------
module wnr_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [63:0]                out_low,
  input logic [47:0]                out_high,
  input logic [wnr_pkg::HITS_W-1:0] out_hits,
  input logic [1:0]                 out_status
);
  import wnr_pkg::*;

  // A stalled result must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_low) && $stable(out_high)
      && $stable(out_hits) && $stable(out_status))
    else $error("result changed while stalled");

  // Table updates report an empty name and no hits.
  a_table_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_REWRITTEN |->
      out_low == '0 && out_high == '0 && out_hits == '0)
    else $error("table update result carries name data");

  // Only one item is in flight at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while busy");

endmodule

bind wildcard_name_rewrite wnr_checker u_wnr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_low   (out_low),
  .out_high  (out_high),
  .out_hits  (out_hits),
  .out_status(out_status)
);
